/* hw/rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the infix to postfix converter: character
// codes, stacked operator codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // ascii characters the converter recognizes
  localparam logic [7:0] CH_TERM    = 8'h00;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // operator codes as held on the stack
  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_LPAREN = 3'd0;
  localparam opcode_t OP_PLUS   = 3'd1;
  localparam opcode_t OP_MINUS  = 3'd2;
  localparam opcode_t OP_MUL    = 3'd3;
  localparam opcode_t OP_DIV    = 3'd4;
  localparam opcode_t OP_POW    = 3'd5;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_OPER,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] symbol;
    opcode_t    code;
  } cmd_t;

endpackage

/* hw/rtl/itp_infix_if.sv */
// ----------------------------------------------------------------------------
// itp_infix_if
// Input channel: one infix character or an end of expression mark.
// ----------------------------------------------------------------------------
interface itp_infix_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

/* hw/rtl/itp_postfix_if.sv */
// ----------------------------------------------------------------------------
// itp_postfix_if
// Output channel: one postfix character with run and overflow flags.
// ----------------------------------------------------------------------------
interface itp_postfix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last_of_run;
  logic       overflow_seen;

  modport source (output valid, output out_symbol, output last_of_run,
                  output overflow_seen, input ready);
  modport sink   (input valid, input out_symbol, input last_of_run,
                  input overflow_seen, output ready);
endinterface

/* hw/rtl/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
//
//   channel   dir   payload                                  handshake
//   infix     in    symbol[7:0], end_of_expr                 valid/ready
//   postfix   out   out_symbol[7:0], last_of_run,            valid/ready
//                   overflow_seen
//
// Back end does at most one stack push or pop per cycle: operands are emitted,
// '(' is pushed, operators pop entries of equal or higher precedence and are
// pushed, ')' pops to its '(', end pops all entries and emits the terminator.
// Front end queues up to two commands, so input flows during pops until full.
// Synchronous reset empties stack and queue; stack ram needs no clearing.
// Back end stalls only on cycles that emit while the output register is held.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  itp_infix_if.sink     infix,
  itp_postfix_if.source postfix
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  itp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .infix     (infix),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .postfix   (postfix)
  );

endmodule

/* hw/rtl/itp_ram.sv */
// ----------------------------------------------------------------------------
// itp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/itp_front.sv */
// ----------------------------------------------------------------------------
// itp_front
// Accepts infix characters, classifies them into commands and queues them
// for the back end. Characters of no meaning are dropped here.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
  input  logic clk,
  input  logic rst,
  itp_infix_if.sink infix,
  output cmd_t cmd,
  output logic cmd_valid,
  input  logic cmd_ready
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  cmd_t new_cmd;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    new_cmd.kind   = CMD_OPERAND;
    new_cmd.symbol = infix.symbol;
    new_cmd.code   = OP_LPAREN;
    keep           = 1'b1;
    if (infix.end_of_expr) begin
      new_cmd.kind = CMD_END;
    end else begin
      unique case (infix.symbol) inside
        [CH_ZERO:CH_NINE], [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: begin
          new_cmd.kind = CMD_OPERAND;
        end
        CH_LPAREN: new_cmd.kind = CMD_LPAREN;
        CH_RPAREN: new_cmd.kind = CMD_RPAREN;
        CH_PLUS: begin
          new_cmd.kind = CMD_OPER;
          new_cmd.code = OP_PLUS;
        end
        CH_MINUS: begin
          new_cmd.kind = CMD_OPER;
          new_cmd.code = OP_MINUS;
        end
        CH_STAR: begin
          new_cmd.kind = CMD_OPER;
          new_cmd.code = OP_MUL;
        end
        CH_SLASH: begin
          new_cmd.kind = CMD_OPER;
          new_cmd.code = OP_DIV;
        end
        CH_DOLLAR: begin
          new_cmd.kind = CMD_OPER;
          new_cmd.code = OP_POW;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign infix.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push        = infix.valid && infix.ready && keep;
  assign pop         = cmd_valid && cmd_ready;
  assign cmd_valid   = (count != '0);
  assign cmd         = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

endmodule

/* hw/rtl/itp_back.sv */
// ----------------------------------------------------------------------------
// itp_back
// Executes queued commands against the operator stack, one push or pop per
// cycle while the output is not held, and drives the postfix output register.
// ----------------------------------------------------------------------------
module itp_back import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_ready,
  itp_postfix_if.source postfix
);

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  function automatic logic [1:0] op_prec(opcode_t c);
    logic [1:0] p;
    case (c) inside
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      OP_POW:            p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_char(opcode_t c);
    logic [7:0] ch;
    case (c)
      OP_LPAREN: ch = CH_LPAREN;
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      OP_MUL:    ch = CH_STAR;
      OP_DIV:    ch = CH_SLASH;
      OP_POW:    ch = CH_DOLLAR;
      default:   ch = CH_TERM;
    endcase
    return ch;
  endfunction

  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic              overflow_flag;
  opcode_t           top;
  opcode_t           below;
  logic [ADDR_W-1:0] rd_addr;

  logic       out_valid;
  logic [7:0] out_symbol;
  logic       out_last;
  logic       out_flag;

  logic       emit;
  logic [7:0] emit_sym;
  logic       emit_last;
  logic       do_push;
  opcode_t    push_code;
  logic       do_pop;
  logic       do_clear;
  logic       done;
  logic       go;
  logic       can_emit;
  logic       nonempty;
  logic       full;
  logic       wr_en;

  assign nonempty = (level != '0);
  assign full     = (level == LVL_W'(STACK_DEPTH));
  assign can_emit = !out_valid || postfix.ready;

  always_comb begin
    emit      = 1'b0;
    emit_sym  = CH_TERM;
    emit_last = 1'b0;
    do_push   = 1'b0;
    push_code = OP_LPAREN;
    do_pop    = 1'b0;
    do_clear  = 1'b0;
    done      = 1'b0;
    unique case (cmd.kind)
      CMD_OPERAND: begin
        emit      = 1'b1;
        emit_sym  = cmd.symbol;
        emit_last = 1'b1;
        done      = 1'b1;
      end
      CMD_LPAREN: begin
        do_push = 1'b1;
        done    = 1'b1;
      end
      CMD_OPER: begin
        if (nonempty && (op_prec(cmd.code) <= op_prec(top))) begin
          do_pop    = 1'b1;
          emit      = 1'b1;
          emit_sym  = op_char(top);
          // last pop when the entry below will not pop too
          emit_last = !((level > LVL_W'(1)) && (op_prec(cmd.code) <= op_prec(below)));
        end else begin
          do_push   = 1'b1;
          push_code = cmd.code;
          done      = 1'b1;
        end
      end
      CMD_RPAREN: begin
        if (!nonempty) begin
          done = 1'b1;
        end else begin
          do_pop = 1'b1;
          if (top == OP_LPAREN) begin
            done = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_sym  = op_char(top);
            emit_last = (level == LVL_W'(1)) || (below == OP_LPAREN);
          end
        end
      end
      CMD_END: begin
        if (nonempty) begin
          do_pop = 1'b1;
          emit   = (top != OP_LPAREN);
          emit_sym = op_char(top);
        end else begin
          emit      = 1'b1;
          emit_sym  = CH_TERM;
          emit_last = 1'b1;
          do_clear  = 1'b1;
          done      = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
  end

  assign go        = cmd_valid && (!emit || can_emit);
  assign cmd_ready = go && done;
  assign wr_en     = go && do_push && !full;

  always_comb begin
    level_next = level;
    if (go) begin
      if (do_clear) begin
        level_next = '0;
      end else if (do_pop) begin
        level_next = level - LVL_W'(1);
      end else if (wr_en) begin
        level_next = level + LVL_W'(1);
      end
    end
  end

  // keep the entry below the top on the ram output at all times
  assign rd_addr = (level_next > LVL_W'(1)) ? ADDR_W'(level_next - LVL_W'(2)) : '0;

  itp_ram #(
    .WIDTH ($bits(opcode_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(level)),
    .wr_data (push_code),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      level <= level_next;
      if (go && do_clear) begin
        overflow_flag <= 1'b0;
      end else if (go && do_push && full) begin
        overflow_flag <= 1'b1;
      end
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (postfix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && do_pop) begin
      top <= below;
    end else if (wr_en) begin
      top <= push_code;
    end
    if (go && emit) begin
      out_symbol <= emit_sym;
      out_last   <= emit_last;
      out_flag   <= overflow_flag;
    end
  end

  assign postfix.valid         = out_valid;
  assign postfix.out_symbol    = out_symbol;
  assign postfix.last_of_run   = out_last;
  assign postfix.overflow_seen = out_flag;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (go && do_clear) |=> (level == '0 && !overflow_flag))
    else $error("end of expression did not clear state");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (go && do_push && full && !do_clear) |=> (overflow_flag && $stable(level)))
    else $error("push on full stack not flagged");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_symbol == CH_TERM) |-> out_last)
    else $error("terminator without last flag");

endmodule

/* verif/tb_infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the shunting-yard converter. A driver feeds infix
// characters from a prebuilt queue with random gaps. A behavioral operator
// stack predicts every postfix character. A monitor with random and long
// backpressure compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter import itp_pkg::*; ();

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 30;

  typedef struct {
    logic [7:0] symbol;
    logic       end_of_expr;
    int         gap_after;
    bit         drain_first;
  } infix_item_t;

  typedef struct {
    logic [7:0] out_symbol;
    logic       last_of_run;
    logic       overflow_seen;
  } postfix_char_t;

  logic clk;
  logic rst;

  itp_infix_if   infix_ch ();
  itp_postfix_if postfix_ch ();

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .infix   (infix_ch),
    .postfix (postfix_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- predictor
  opcode_t       op_stack [STACK_DEPTH];
  int            op_level;
  bit            overflow_sticky;
  postfix_char_t expected_postfix [$];
  int            predicted_total;
  int            results_checked;
  int            error_count;

  function automatic bit is_operand_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic bit decode_operator(input logic [7:0] c, output opcode_t code);
    decode_operator = 1'b1;
    code = OP_LPAREN;
    case (c)
      CH_PLUS:   code = OP_PLUS;
      CH_MINUS:  code = OP_MINUS;
      CH_STAR:   code = OP_MUL;
      CH_SLASH:  code = OP_DIV;
      CH_DOLLAR: code = OP_POW;
      default:   decode_operator = 1'b0;
    endcase
  endfunction

  function automatic int op_rank(input opcode_t code);
    case (code)
      OP_PLUS, OP_MINUS: return 1;
      OP_MUL, OP_DIV:    return 2;
      OP_POW:            return 3;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input opcode_t code);
    case (code)
      OP_PLUS:  return CH_PLUS;
      OP_MINUS: return CH_MINUS;
      OP_MUL:   return CH_STAR;
      OP_DIV:   return CH_SLASH;
      OP_POW:   return CH_DOLLAR;
      default:  return CH_LPAREN;
    endcase
  endfunction

  task automatic push_op(input opcode_t code);
    if (op_level >= STACK_DEPTH) begin
      overflow_sticky = 1'b1;
    end else begin
      op_stack[op_level] = code;
      op_level++;
    end
  endtask

  task automatic predict_postfix(input logic [7:0] sym, input logic eoe);
    logic [7:0]    outs [$];
    opcode_t       code;
    opcode_t       top;
    bit            flag;
    postfix_char_t pc;
    if (eoe) begin
      while (op_level > 0) begin
        top = op_stack[op_level-1];
        op_level--;
        if (top != OP_LPAREN) outs.push_back(op_char(top));
      end
      outs.push_back(CH_TERM);
      flag = overflow_sticky;
      overflow_sticky = 1'b0;
    end else begin
      if (is_operand_char(sym)) begin
        outs.push_back(sym);
      end else if (sym == CH_LPAREN) begin
        push_op(OP_LPAREN);
      end else if (sym == CH_RPAREN) begin
        // pops down to the matching paren, or empties the stack if unmatched
        while (op_level > 0) begin
          top = op_stack[op_level-1];
          op_level--;
          if (top == OP_LPAREN) break;
          outs.push_back(op_char(top));
        end
      end else if (decode_operator(sym, code)) begin
        while (op_level > 0 && op_rank(code) <= op_rank(op_stack[op_level-1])) begin
          outs.push_back(op_char(op_stack[op_level-1]));
          op_level--;
        end
        push_op(code);
      end
      flag = overflow_sticky;
    end
    foreach (outs[i]) begin
      pc.out_symbol    = outs[i];
      pc.last_of_run   = (i == outs.size() - 1);
      pc.overflow_seen = flag;
      expected_postfix.push_back(pc);
    end
    predicted_total += outs.size();
  endtask

  // ---------------------------------------------------------------- stimulus
  infix_item_t pending_infix [$];
  int          gap_max;
  bit          drain_next;

  task automatic add_item(input logic [7:0] sym, input logic eoe);
    infix_item_t it;
    it.symbol      = sym;
    it.end_of_expr = eoe;
    it.gap_after   = $urandom_range(0, gap_max);
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    pending_infix.push_back(it);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_LOWER_A + 8'($urandom_range(0, 25));
      default: return CH_UPPER_A + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_DOLLAR;
    endcase
  endfunction

  function automatic logic [7:0] rand_noise();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 255));
      1:       return CH_LPAREN;
      2:       return CH_RPAREN;
      3:       return rand_operator();
      default: return rand_operand();
    endcase
  endfunction

  task automatic add_expression();
    int terms;
    int open_parens;
    terms = $urandom_range(1, 8);
    open_parens = 0;
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_item(rand_operator(), 1'b0);
      while (open_parens < 4 && $urandom_range(0, 3) == 0) begin
        add_item(CH_LPAREN, 1'b0);
        open_parens++;
      end
      add_item(rand_operand(), 1'b0);
      while (open_parens > 0 && $urandom_range(0, 2) == 0) begin
        add_item(CH_RPAREN, 1'b0);
        open_parens--;
      end
    end
    while (open_parens > 0) begin
      add_item(CH_RPAREN, 1'b0);
      open_parens--;
    end
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_broken();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) add_item(rand_noise(), 1'b0);
    if ($urandom_range(0, 99) < 85) add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // nests deep enough that it can overrun the operator stack
  task automatic add_deep_nest();
    int levels;
    levels = $urandom_range(14, 24);
    repeat (levels) begin
      add_item(CH_LPAREN, 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        add_item(rand_operand(), 1'b0);
        add_item(rand_operator(), 1'b0);
      end
    end
    add_item(rand_operand(), 1'b0);
    repeat ($urandom_range(0, 6)) add_item(CH_RPAREN, 1'b0);
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic build_stimulus();
    int r;
    gap_max = 16;
    drain_next = 1'b0;
    // precedence with operand extremes, ignored symbol on the end transaction
    add_item(CH_UPPER_A, 1'b0);
    add_item(CH_PLUS, 1'b0);
    add_item(CH_NINE, 1'b0);
    add_item(CH_STAR, 1'b0);
    add_item(CH_LOWER_Z, 1'b0);
    add_item(CH_PLUS, 1'b1);
    // parens, minus, divide, left associative power
    add_item(CH_LPAREN, 1'b0);
    add_item(CH_LOWER_A, 1'b0);
    add_item(CH_MINUS, 1'b0);
    add_item(CH_UPPER_Z, 1'b0);
    add_item(CH_RPAREN, 1'b0);
    add_item(CH_SLASH, 1'b0);
    add_item(CH_ZERO, 1'b0);
    add_item(CH_DOLLAR, 1'b0);
    add_item(CH_UPPER_Z, 1'b0);
    add_item(CH_DOLLAR, 1'b0);
    add_item(CH_LOWER_Z, 1'b0);
    add_item(CH_TERM, 1'b1);
    // unmatched close, unmatched open, characters next to the operand ranges
    add_item(CH_LOWER_A, 1'b0);
    add_item(CH_PLUS, 1'b0);
    add_item(CH_NINE, 1'b0);
    add_item(CH_RPAREN, 1'b0);
    add_item(CH_LPAREN, 1'b0);
    add_item(CH_NINE + 8'd1, 1'b0);
    add_item(CH_UPPER_A - 8'd1, 1'b0);
    add_item(8'hFF, 1'b1);
    // random part, the first sequence waits for the directed results to drain
    drain_next = 1'b1;
    add_deep_nest();
    while (pending_infix.size() < 440) begin
      gap_max = ($urandom_range(0, 9) < 3) ? 0 : 16;
      if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70) add_expression();
      else if (r < 88) add_broken();
      else add_deep_nest();
    end
  endtask

  // ---------------------------------------------------------------- driver
  int send_wait;
  int cur_gap_after;

  always @(posedge clk) begin
    infix_item_t nxt;
    if (rst) begin
      infix_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (infix_ch.valid && infix_ch.ready) begin
        predict_postfix(infix_ch.symbol, infix_ch.end_of_expr);
        send_wait = cur_gap_after;
      end
      if (!infix_ch.valid || infix_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          infix_ch.valid <= 1'b0;
        end else if (pending_infix.size() == 0) begin
          infix_ch.valid <= 1'b0;
        end else if (pending_infix[0].drain_first && predicted_total != results_checked) begin
          infix_ch.valid <= 1'b0;
        end else begin
          nxt = pending_infix.pop_front();
          cur_gap_after = nxt.gap_after;
          infix_ch.valid       <= 1'b1;
          infix_ch.symbol      <= nxt.symbol;
          infix_ch.end_of_expr <= nxt.end_of_expr;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int  hold_left;
  int  hold_max;

  always @(posedge clk) begin
    postfix_char_t exp_pc;
    int            seen;
    if (rst) begin
      postfix_ch.ready <= 1'b0;
      hold_left = 0;
      hold_max  = 16;
    end else begin
      if (postfix_ch.valid && postfix_ch.ready) begin
        seen = results_checked + 1;
        results_checked <= seen;
        if (expected_postfix.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected transaction, actual sym=%h last=%b ovf=%b", $time,
                     postfix_ch.out_symbol, postfix_ch.last_of_run, postfix_ch.overflow_seen);
        end else begin
          exp_pc = expected_postfix.pop_front();
          if (postfix_ch.out_symbol !== exp_pc.out_symbol ||
              postfix_ch.last_of_run !== exp_pc.last_of_run ||
              postfix_ch.overflow_seen !== exp_pc.overflow_seen) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch, expected sym=%h last=%b ovf=%b, actual sym=%h last=%b ovf=%b",
                       $time, exp_pc.out_symbol, exp_pc.last_of_run, exp_pc.overflow_seen,
                       postfix_ch.out_symbol, postfix_ch.last_of_run,
                       postfix_ch.overflow_seen);
          end
        end
        if (seen % 50 == 0) hold_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
        // one long hold so the converter fills up and stalls its input
        if (seen == 60) hold_left = LONG_HOLD;
        else hold_left = $urandom_range(0, hold_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        postfix_ch.ready <= 1'b0;
      end else begin
        postfix_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (infix_ch.valid && infix_ch.ready) || (postfix_ch.valid && postfix_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    infix_ch.valid       = 1'b0;
    infix_ch.symbol      = 8'h00;
    infix_ch.end_of_expr = 1'b0;
    postfix_ch.ready     = 1'b0;
    op_level        = 0;
    overflow_sticky = 1'b0;
    predicted_total = 0;
    results_checked = 0;
    error_count     = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_infix.size() != 0 || infix_ch.valid ||
               results_checked != predicted_total);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_postfix.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/itp_pkg.sv
hw/rtl/itp_infix_if.sv
hw/rtl/itp_postfix_if.sv
hw/rtl/itp_ram.sv
hw/rtl/itp_front.sv
hw/rtl/itp_back.sv
hw/rtl/infix_to_postfix_converter.sv
verif/tb_infix_to_postfix_converter.sv
